>>> hw/rtl/tcfw_pkg.sv
// Shared types and constants for the texture combine / framebuffer write block.
// No dependencies.
`default_nettype none

package tcfw_pkg;

	typedef struct packed {
		logic signed [11:0] pos_x;
		logic signed [11:0] pos_y;
		logic [31:0]        vertex_color;
		logic [31:0]        texel_word;
		logic [31:0]        old_pixel;
	} frag_t;

	typedef struct packed {
		logic        write_enable;
		logic [31:0] write_value;
		logic [31:0] shaded_color;
	} px_t;

	localparam int CfgIndexW = 3;
	localparam int CfgDataW  = 32;
	localparam int CoordW    = 11;

	localparam logic [CfgIndexW-1:0] CFG_TEXTURE_MODE   = 3'd0;
	localparam logic [CfgIndexW-1:0] CFG_TARGET_FORMAT  = 3'd1;
	localparam logic [CfgIndexW-1:0] CFG_WRITE_MASK     = 3'd2;
	localparam logic [CfgIndexW-1:0] CFG_SCISSOR_LEFT   = 3'd3;
	localparam logic [CfgIndexW-1:0] CFG_SCISSOR_RIGHT  = 3'd4;
	localparam logic [CfgIndexW-1:0] CFG_SCISSOR_TOP    = 3'd5;
	localparam logic [CfgIndexW-1:0] CFG_SCISSOR_BOTTOM = 3'd6;

	// texture_mode bits
	localparam int TM_ENABLE    = 0;
	localparam int TM_DECAL     = 1;
	localparam int TM_TEX_ALPHA = 2;
	localparam int TM_TEX_24    = 3;

	localparam logic [1:0] FMT_32 = 2'd0;
	localparam logic [1:0] FMT_24 = 2'd1;

	localparam logic [31:0] RGB_MASK   = 32'h00FF_FFFF;
	localparam logic [31:0] ALPHA_MASK = 32'hFF00_0000;
	localparam logic [31:0] ALPHA_HALF = 32'h8000_0000;
	localparam logic [31:0] RB_MASK    = 32'h00F8_00F8;
	localparam logic [31:0] GA_MASK    = 32'h8000_F800;

	function automatic logic [15:0] pack5551(input logic [31:0] c);
		logic [31:0] rb;
		logic [31:0] ga;
		logic [31:0] w;
		rb = c & RB_MASK;
		ga = c & GA_MASK;
		w  = (ga >> 16) | (rb >> 9) | (ga >> 6) | (rb >> 3);
		return w[15:0];
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/tcfw_combine.sv
// Texture combine: pass-through, decal or saturating modulate of texel and vertex color.
// Depends on tcfw_pkg.
`default_nettype none

module tcfw_combine
	import tcfw_pkg::*;
(
	input  wire logic [3:0]  texture_mode,
	input  wire logic [31:0] vertex_color,
	input  wire logic [31:0] texel_word,
	output logic      [31:0] shaded_color
);

	function automatic logic [7:0] mod_sat(input logic [7:0] t, input logic [7:0] v);
		logic [15:0] p;
		p = t * v;
		return p[15] ? 8'hFF : p[14:7];
	endfunction

	logic [31:0] tex;
	logic [7:0]  alpha;

	always_comb begin
		tex = texture_mode[TM_TEX_24] ? ((texel_word & RGB_MASK) | ALPHA_HALF) : texel_word;
		alpha = texture_mode[TM_TEX_ALPHA] ? mod_sat(tex[31:24], vertex_color[31:24])
		                                   : vertex_color[31:24];
		if (!texture_mode[TM_ENABLE]) begin
			shaded_color = vertex_color;
		end else if (texture_mode[TM_DECAL]) begin
			shaded_color = (tex & RGB_MASK) |
				(texture_mode[TM_TEX_ALPHA] ? (tex & ALPHA_MASK) : (vertex_color & ALPHA_MASK));
		end else begin
			shaded_color = {alpha,
				mod_sat(tex[23:16], vertex_color[23:16]),
				mod_sat(tex[15:8], vertex_color[15:8]),
				mod_sat(tex[7:0], vertex_color[7:0])};
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/texture_combine_framebuffer_write.sv
// Fragment back end: texture combine, scissor test and masked framebuffer word.
// Depends on tcfw_pkg and tcfw_combine.
//
// Usage:
//   frag channel (frag_valid / frag_stall / frag) carries one fragment per
//   transaction: position, vertex color, fetched texel and old framebuffer word.
//   px channel (px_valid / px_stall / px) returns one result per fragment:
//   write enable, word to store and the combined color.
//   Configuration is written through cfg_write / cfg_index / cfg_data while the
//   block holds no transaction; writes take effect at the next clock edge.
//   A fragment passes an input register, then the combine/scissor/merge
//   logic into the output register. One fragment per cycle is sustained while
//   px_stall is low, set by the single input stage and single output stage.
//   When px_stall is high with px_valid set the output register holds; an empty
//   input register takes one more fragment, then frag_stall rises until px drains.
//   arst_n clears both stage valids and returns registers to their reset values
//   (scissor full range, texturing off, 32-bit target, empty mask).
`default_nettype none

module texture_combine_framebuffer_write
	import tcfw_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 frag_valid,
	output logic                      frag_stall,
	input  wire frag_t                frag,
	output logic                      px_valid,
	input  wire logic                 px_stall,
	output px_t                       px,
	input  wire logic                 cfg_write,
	input  wire logic [CfgIndexW-1:0] cfg_index,
	input  wire logic [CfgDataW-1:0]  cfg_data
);

	logic [3:0]        texture_mode_q;
	logic [1:0]        target_format_q;
	logic [31:0]       write_mask_q;
	logic [CoordW-1:0] scissor_left_q;
	logic [CoordW-1:0] scissor_right_q;
	logic [CoordW-1:0] scissor_top_q;
	logic [CoordW-1:0] scissor_bottom_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			texture_mode_q   <= '0;
			target_format_q  <= FMT_32;
			write_mask_q     <= '0;
			scissor_left_q   <= '0;
			scissor_right_q  <= '1;
			scissor_top_q    <= '0;
			scissor_bottom_q <= '1;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_TEXTURE_MODE:   texture_mode_q   <= cfg_data[3:0];
				CFG_TARGET_FORMAT:  target_format_q  <= cfg_data[1:0];
				CFG_WRITE_MASK:     write_mask_q     <= cfg_data[31:0];
				CFG_SCISSOR_LEFT:   scissor_left_q   <= cfg_data[CoordW-1:0];
				CFG_SCISSOR_RIGHT:  scissor_right_q  <= cfg_data[CoordW-1:0];
				CFG_SCISSOR_TOP:    scissor_top_q    <= cfg_data[CoordW-1:0];
				CFG_SCISSOR_BOTTOM: scissor_bottom_q <= cfg_data[CoordW-1:0];
				default: ;
			endcase
		end
	end

	// pipeline control
	logic  vld_s1;
	logic  vld_s2;
	frag_t frag_s1;
	px_t   px_s2;
	px_t   px_d;
	logic  adv_s2;
	logic  adv_s1;

	assign adv_s2     = !vld_s2 || !px_stall;
	assign adv_s1     = !vld_s1 || adv_s2;
	assign frag_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				vld_s1 <= frag_valid;
			end
			if (adv_s2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && frag_valid) begin
			frag_s1 <= frag;
		end
		if (adv_s2 && vld_s1) begin
			px_s2 <= px_d;
		end
	end

	// stage 1 logic
	logic [31:0] shaded;
	logic        in_scissor;
	logic [31:0] mask24;

	tcfw_combine u_combine (
		.texture_mode (texture_mode_q),
		.vertex_color (frag_s1.vertex_color),
		.texel_word   (frag_s1.texel_word),
		.shaded_color (shaded)
	);

	always_comb begin
		in_scissor = !frag_s1.pos_x[11] && !frag_s1.pos_y[11] &&
			(frag_s1.pos_x[CoordW-1:0] >= scissor_left_q) &&
			(frag_s1.pos_x[CoordW-1:0] <= scissor_right_q) &&
			(frag_s1.pos_y[CoordW-1:0] >= scissor_top_q) &&
			(frag_s1.pos_y[CoordW-1:0] <= scissor_bottom_q);
		mask24 = write_mask_q & RGB_MASK;
		px_d.write_enable = in_scissor;
		px_d.shaded_color = shaded;
		px_d.write_value  = '0;
		if (in_scissor) begin
			priority if (target_format_q == FMT_32) begin
				px_d.write_value = (frag_s1.old_pixel & write_mask_q) | (shaded & ~write_mask_q);
			end else if (target_format_q == FMT_24) begin
				px_d.write_value = (frag_s1.old_pixel & mask24) | (shaded & ~mask24 & RGB_MASK);
			end else begin
				px_d.write_value = {16'h0000, pack5551(shaded)};
			end
		end
	end

	assign px_valid = vld_s2;
	assign px       = px_s2;

endmodule

`default_nettype wire

>>> hw/rtl/tcfw_checker.sv
// Port-level checks for texture_combine_framebuffer_write, attached by bind.
// Depends on tcfw_pkg.
`default_nettype none

module tcfw_checker
	import tcfw_pkg::*;
(
	input wire logic  clk,
	input wire logic  arst_n,
	input wire logic  frag_valid,
	input wire logic  frag_stall,
	input wire frag_t frag,
	input wire logic  px_valid,
	input wire logic  px_stall,
	input wire px_t   px
);

	a_px_hold: assert property (@(posedge clk) disable iff (!arst_n)
		px_valid && px_stall |=> px_valid && $stable(px))
		else $error("result changed while stalled");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(frag_valid && !frag_stall) ##1 !px_stall |=> px_valid)
		else $error("result missing two cycles after transaction");

	a_neg_x: assert property (@(posedge clk) disable iff (!arst_n)
		(frag_valid && !frag_stall && frag.pos_x[11]) ##1 !px_stall |=> !px.write_enable)
		else $error("negative column written");

	a_no_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		px_valid && !px.write_enable |-> px.write_value == 32'h0)
		else $error("write value nonzero outside scissor");

endmodule

bind texture_combine_framebuffer_write tcfw_checker u_tcfw_checker (.*);

`default_nettype wire

>>> tb/texture_combine_framebuffer_write_tb.sv
// Testbench for texture_combine_framebuffer_write: directed and random fragments,
// results checked against an in-bench predictor of combine, scissor and merge.
// Depends on tcfw_pkg and the RTL of the block.
`timescale 1ns / 100ps

module texture_combine_framebuffer_write_tb
	import tcfw_pkg::*;
;

	localparam logic [1:0] FMT_5551       = 2'd2;
	localparam logic [1:0] FMT_5551_ALIAS = 2'd3;
	localparam int         FRAG_SEGMENTS  = 31;
	localparam int         SEGMENT_FRAGS  = 50;
	localparam int         REPORT_LIMIT   = 10;

	class px_scoreboard;
		logic [3:0]  tex_mode;
		logic [1:0]  fb_format;
		logic [31:0] keep_mask;
		logic [10:0] sc_left, sc_right, sc_top, sc_bottom;
		px_t         expected_px[$];
		int          errors;

		function new();
			tex_mode  = '0;
			fb_format = FMT_32;
			keep_mask = '0;
			sc_left   = '0;
			sc_right  = 11'd2047;
			sc_top    = '0;
			sc_bottom = 11'd2047;
			errors    = 0;
		endfunction

		function void set_reg(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] data);
			case (idx)
				CFG_TEXTURE_MODE:   tex_mode  = data[3:0];
				CFG_TARGET_FORMAT:  fb_format = data[1:0];
				CFG_WRITE_MASK:     keep_mask = data;
				CFG_SCISSOR_LEFT:   sc_left   = data[10:0];
				CFG_SCISSOR_RIGHT:  sc_right  = data[10:0];
				CFG_SCISSOR_TOP:    sc_top    = data[10:0];
				CFG_SCISSOR_BOTTOM: sc_bottom = data[10:0];
				default: ;
			endcase
		endfunction

		function logic [7:0] modulate(logic [7:0] t, logic [7:0] v);
			logic [15:0] p;
			p = t * v;
			p = p >> 7;
			return (p > 16'd255) ? 8'hFF : p[7:0];
		endfunction

		function logic [31:0] shade(logic [31:0] vert, logic [31:0] tex_raw);
			logic [31:0] tex;
			logic [7:0]  alpha;
			if (!tex_mode[TM_ENABLE])
				return vert;
			tex = tex_mode[TM_TEX_24] ? ((tex_raw & RGB_MASK) | ALPHA_HALF) : tex_raw;
			if (tex_mode[TM_DECAL]) begin
				alpha = tex_mode[TM_TEX_ALPHA] ? tex[31:24] : vert[31:24];
				return {alpha, tex[23:0]};
			end
			alpha = tex_mode[TM_TEX_ALPHA] ? modulate(tex[31:24], vert[31:24]) : vert[31:24];
			return {alpha, modulate(tex[23:16], vert[23:16]),
				modulate(tex[15:8], vert[15:8]), modulate(tex[7:0], vert[7:0])};
		endfunction

		function void note_fragment(frag_t f);
			px_t         r;
			int          x, y;
			logic [31:0] m;
			x = $signed(f.pos_x);
			y = $signed(f.pos_y);
			r.shaded_color = shade(f.vertex_color, f.texel_word);
			r.write_enable = x >= int'(sc_left) && x <= int'(sc_right) &&
				y >= int'(sc_top) && y <= int'(sc_bottom);
			r.write_value = '0;
			if (r.write_enable) begin
				case (fb_format)
					FMT_32: r.write_value = (f.old_pixel & keep_mask) |
						(r.shaded_color & ~keep_mask);
					FMT_24: begin
						m = keep_mask & RGB_MASK;
						r.write_value = (f.old_pixel & m) | (r.shaded_color & ~m & RGB_MASK);
					end
					default: r.write_value = {16'h0, r.shaded_color[31], r.shaded_color[23:19],
						r.shaded_color[15:11], r.shaded_color[7:3]};
				endcase
			end
			expected_px.push_back(r);
		endfunction

		function void check_px(px_t got);
			px_t want;
			if (expected_px.size() == 0) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("unexpected result transaction: %h", got);
				return;
			end
			want = expected_px.pop_front();
			if (got.write_enable !== want.write_enable || got.write_value !== want.write_value ||
					got.shaded_color !== want.shaded_color) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("mismatch: we exp %b got %b, value exp %h got %h, color exp %h got %h",
						want.write_enable, got.write_enable, want.write_value,
						got.write_value, want.shaded_color, got.shaded_color);
			end
		endfunction

		function int pending();
			return expected_px.size();
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 frag_valid = 1'b0;
	logic                 frag_stall;
	frag_t                frag = '0;
	logic                 px_valid;
	logic                 px_stall = 1'b0;
	px_t                  px;
	logic                 cfg_write = 1'b0;
	logic [CfgIndexW-1:0] cfg_index = '0;
	logic [CfgDataW-1:0]  cfg_data = '0;

	int           send_idle_pct = 0;
	int           stall_pct = 0;
	px_scoreboard board;

	logic [10:0] cur_left, cur_right, cur_top, cur_bottom;

	texture_combine_framebuffer_write u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.frag_valid (frag_valid),
		.frag_stall (frag_stall),
		.frag       (frag),
		.px_valid   (px_valid),
		.px_stall   (px_stall),
		.px         (px),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		px_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && board != null) begin
			if (cfg_write)
				board.set_reg(cfg_index, cfg_data);
			if (frag_valid && !frag_stall)
				board.note_fragment(frag);
			if (px_valid && !px_stall)
				board.check_px(px);
		end
	end

	function frag_t make_frag(logic [11:0] x, logic [11:0] y, logic [31:0] vert,
			logic [31:0] tex, logic [31:0] old);
		frag_t f;
		f.pos_x        = x;
		f.pos_y        = y;
		f.vertex_color = vert;
		f.texel_word   = tex;
		f.old_pixel    = old;
		return f;
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_fragment(frag_t f);
		while ($urandom_range(99) < send_idle_pct) begin
			frag_valid = 1'b0;
			@(negedge clk);
		end
		frag       = f;
		frag_valid = 1'b1;
		do
			@(posedge clk);
		while (frag_stall);
		@(negedge clk);
	endtask

	task automatic send_at(logic [11:0] x, logic [11:0] y);
		send_fragment(make_frag(x, y, $urandom, $urandom, $urandom));
	endtask

	task automatic drain();
		frag_valid = 1'b0;
		while (board.pending() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_config(logic [31:0] mode, logic [31:0] fmt, logic [31:0] mask,
			logic [31:0] l, logic [31:0] r, logic [31:0] t, logic [31:0] b);
		logic [CfgIndexW-1:0] idx[7];
		logic [31:0]          val[7];
		idx = '{CFG_TEXTURE_MODE, CFG_TARGET_FORMAT, CFG_WRITE_MASK, CFG_SCISSOR_LEFT,
			CFG_SCISSOR_RIGHT, CFG_SCISSOR_TOP, CFG_SCISSOR_BOTTOM};
		val = '{mode, fmt, mask, l, r, t, b};
		cur_left   = l[10:0];
		cur_right  = r[10:0];
		cur_top    = t[10:0];
		cur_bottom = b[10:0];
		for (int i = 0; i < 7; i++) begin
			cfg_index = idx[i];
			cfg_data  = val[i];
			cfg_write = 1'b1;
			@(negedge clk);
		end
		cfg_write = 1'b0;
	endtask

	function logic [10:0] pick_bound();
		case ($urandom_range(3))
			0: return 11'd0;
			1: return 11'd2047;
			default: return 11'($urandom);
		endcase
	endfunction

	function logic [11:0] pick_pos(logic [10:0] lo, logic [10:0] hi);
		int base, span;
		if ($urandom_range(2) == 0)
			return 12'($urandom);
		base = (lo <= hi) ? int'(lo) : int'(hi);
		span = (lo <= hi) ? int'(hi) - int'(lo) : int'(lo) - int'(hi);
		return 12'(base - 2 + int'($urandom_range(span + 4)));
	endfunction

	task automatic random_segment();
		logic [10:0] a, b, c, d;
		logic [31:0] mask;
		a = pick_bound();
		b = pick_bound();
		c = pick_bound();
		d = pick_bound();
		// mostly a proper rectangle, sometimes inverted
		if ($urandom_range(4) != 0) begin
			if (a > b) {a, b} = {b, a};
			if (c > d) {c, d} = {d, c};
		end
		case ($urandom_range(3))
			0: mask = '0;
			1: mask = '1;
			default: mask = $urandom;
		endcase
		// junk above the register width must be ignored
		write_config({28'($urandom), 4'($urandom)} , {30'($urandom), 2'($urandom)}, mask,
			{21'($urandom), a}, {21'($urandom), b}, {21'($urandom), c}, {21'($urandom), d});
		for (int i = 0; i < SEGMENT_FRAGS; i++)
			send_fragment(make_frag(pick_pos(cur_left, cur_right), pick_pos(cur_top, cur_bottom),
				$urandom, $urandom, $urandom));
		drain();
	endtask

	initial begin
		board = new();
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings: pass-through, full scissor, negative positions
		send_at(12'h800, 12'h000);
		send_at(12'h7FF, 12'h7FF);
		send_at(12'h000, 12'h000);
		send_at(12'hFFF, 12'h005);
		drain();

		// modulate with texture alpha, scissor edges
		write_config(32'h5, 32'(FMT_32), 32'h0F0F_0F0F, 10, 20, 30, 40);
		send_fragment(make_frag(12'd10, 12'd30, 32'hFFFF_FFFF, 32'hFFFF_FFFF, $urandom));
		send_fragment(make_frag(12'd20, 12'd40, 32'h0000_0000, 32'hFFFF_FFFF, $urandom));
		send_fragment(make_frag(12'd9, 12'd35, 32'h8080_8080, 32'h8080_8080, $urandom));
		send_at(12'd21, 12'd35);
		send_at(12'd15, 12'd29);
		send_at(12'd15, 12'd41);
		drain();

		write_config(32'hF, 32'(FMT_24), 32'hFFFF_FFFF, 0, 2047, 0, 2047);
		send_at(12'd100, 12'd100);
		send_fragment(make_frag(12'd0, 12'd2047, $urandom, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		drain();

		write_config(32'h3, 32'(FMT_5551), 32'h1234_5678, 0, 2047, 0, 2047);
		send_fragment(make_frag(12'd5, 12'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0));
		send_at(12'd2047, 12'd0);
		drain();

		// inverted scissor
		write_config(32'h7, 32'(FMT_5551_ALIAS), 32'h0, 100, 50, 0, 2047);
		send_at(12'd75, 12'd75);
		send_at(12'd100, 12'd10);
		drain();
		write_config(32'h7, 32'(FMT_5551_ALIAS), 32'h0, 0, 2047, 60, 20);
		send_at(12'd75, 12'd40);
		drain();

		write_config(32'hD, 32'(FMT_32), 32'h0, 0, 2047, 0, 2047);
		send_fragment(make_frag(12'd1, 12'd1, 32'hFFFF_FFFF, 32'h00FF_FFFF, $urandom));
		send_at(12'd2, 12'd2);
		drain();
		write_config(32'hE, 32'(FMT_24), 32'h00F0_F0F0, 0, 2047, 0, 2047);
		send_at(12'd3, 12'd3);
		drain();

		for (int s = 0; s < FRAG_SEGMENTS; s++) begin
			case (s % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 77; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 77; end
				default: begin send_idle_pct = 18; stall_pct = 18; end
			endcase
			random_segment();
		end

		stall_pct = 0;
		drain();
		if (board.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/tcfw_pkg.sv
hw/rtl/tcfw_combine.sv
hw/rtl/texture_combine_framebuffer_write.sv
hw/rtl/tcfw_checker.sv
tb/texture_combine_framebuffer_write_tb.sv
